>>> hw/rtl/blr_pkg.sv
// Shared types and constants for the line rasterizer with color interpolation.
// Used by the controller, the datapath, the top level and the port checker.
`timescale 1ns / 1ps
`default_nettype none

package blr_pkg;

  // Kinds of input transaction, carried on in_tuser.
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_STEP = 1'b1;

  localparam int COORD_W   = 9;
  localparam int ERR_W     = 12;
  localparam int CHAN_W    = 8;
  localparam int NUM_CHAN  = 4;
  localparam int COLOR_W   = 32;
  localparam int ADDR_W    = 20;
  localparam int DIV_CNT_W = 3;
  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 72;

  // Controller states, one-hot.
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_OUT  = 3'b100
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic div_step;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic line_active;
    logic div_last;
  } status_t;

endpackage

`default_nettype wire

>>> hw/rtl/blr_ctrl.sv
// Controller state machine of the line rasterizer.
// Depends on blr_pkg; drives the datapath through cmd_t and reads status_t.
`timescale 1ns / 1ps
`default_nettype none

module blr_ctrl (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_tvalid,
  output logic             in_tready,
  input  wire              in_mode,
  output logic             out_tvalid,
  input  wire              out_tready,
  input  blr_pkg::status_t status,
  output blr_pkg::cmd_t    cmd
);
  import blr_pkg::*;

  state_t state_r, state_nxt;

  // Next state and commands.
  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_mode == MODE_LOAD) begin
            cmd.load  = 1'b1;
            state_nxt = ST_DIV;
          end else if (status.line_active) begin
            cmd.step  = 1'b1;
            state_nxt = ST_OUT;
          end
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/blr_datapath.sv
// Datapath of the line rasterizer: line state, midpoint stepping, the
// per-channel restoring divider and the color accumulators. Depends on blr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module blr_datapath #(
  parameter int WIDTH = 512
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  blr_pkg::cmd_t                cmd,
  output blr_pkg::status_t             status,
  input  wire [blr_pkg::IN_DATA_W-1:0] in_data,
  output logic [blr_pkg::OUT_DATA_W-1:0] out_data,
  output logic                         out_last
);
  import blr_pkg::*;

  // Line state.
  logic [COORD_W-1:0]    cur_x_r, cur_y_r, major_r, minor_r, step_r;
  logic signed [ERR_W-1:0] err_r;
  logic                  xmaj_r, ydown_r, active_r;
  logic [COLOR_W-1:0]    cfrom_r;
  // Per-channel divider and accumulators. quo_r holds the dividend, then the quotient.
  logic [NUM_CHAN-1:0]   neg_r;
  logic [CHAN_W-1:0]     quo_r  [NUM_CHAN];
  logic [COORD_W-1:0]    rem_r  [NUM_CHAN];
  logic [CHAN_W-1:0]     accq_r [NUM_CHAN];
  logic [COORD_W-1:0]    accr_r [NUM_CHAN];
  logic [DIV_CNT_W-1:0]  divcnt_r;

  // Load decode: swap endpoints so x never decreases.
  logic [COORD_W-1:0] xs, ys, xe, ye, x0, y0, x1, y1, dx, dy, ld_maj, ld_min;
  logic [COLOR_W-1:0] cs, ce, c0, c1;
  logic               swap, ld_ydown, ld_xmaj;
  logic signed [ERR_W-1:0] ld_err;

  always_comb begin
    xs = in_data[8:0];
    ys = in_data[17:9];
    xe = in_data[26:18];
    ye = in_data[35:27];
    cs = in_data[67:36];
    ce = in_data[99:68];
    swap = xe < xs;
    x0 = swap ? xe : xs;
    y0 = swap ? ye : ys;
    x1 = swap ? xs : xe;
    y1 = swap ? ys : ye;
    c0 = swap ? ce : cs;
    c1 = swap ? cs : ce;
    dx = x1 - x0;
    ld_ydown = y1 < y0;
    dy = ld_ydown ? (y0 - y1) : (y1 - y0);
    ld_xmaj = dx > dy;
    ld_maj = ld_xmaj ? dx : dy;
    ld_min = ld_xmaj ? dy : dx;
    ld_err = $signed({2'b00, ld_min, 1'b0}) - $signed({3'b000, ld_maj});
  end

  // Midpoint step.
  logic                    minor_move, move_x, move_y;
  logic signed [ERR_W-1:0] st_err;
  logic [COORD_W-1:0]      st_count;

  always_comb begin
    minor_move = err_r > 0;
    move_x = xmaj_r || minor_move;
    move_y = !xmaj_r || minor_move;
    st_err = err_r + $signed({2'b00, minor_r, 1'b0})
           - (minor_move ? $signed({2'b00, major_r, 1'b0}) : $signed(ERR_W'(0)));
    st_count = step_r + COORD_W'(1);
  end

  // Per-channel combinational pieces: load magnitude, divider trial, accumulator step.
  logic [CHAN_W-1:0]  ld_a [NUM_CHAN];
  logic [CHAN_W-1:0]  ld_b [NUM_CHAN];
  logic [NUM_CHAN-1:0] ld_neg;
  logic [CHAN_W-1:0]  ld_mag [NUM_CHAN];
  logic [COORD_W:0]   trial [NUM_CHAN];
  logic               tfit [NUM_CHAN];
  logic [COORD_W:0]   rsum [NUM_CHAN];
  logic               rwrap [NUM_CHAN];
  logic [CHAN_W-1:0]  chan_out [NUM_CHAN];

  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      ld_a[c]   = c0[c*CHAN_W +: CHAN_W];
      ld_b[c]   = c1[c*CHAN_W +: CHAN_W];
      ld_neg[c] = ld_b[c] < ld_a[c];
      ld_mag[c] = ld_neg[c] ? (ld_a[c] - ld_b[c]) : (ld_b[c] - ld_a[c]);
      trial[c]  = {rem_r[c], quo_r[c][CHAN_W-1]};
      tfit[c]   = trial[c] >= {1'b0, major_r};
      rsum[c]   = {1'b0, accr_r[c]} + {1'b0, rem_r[c]};
      rwrap[c]  = rsum[c] >= {1'b0, major_r};
      chan_out[c] = neg_r[c] ? (cfrom_r[c*CHAN_W +: CHAN_W] - accq_r[c])
                             : (cfrom_r[c*CHAN_W +: CHAN_W] + accq_r[c]);
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r  <= '0;
      cur_y_r  <= '0;
      major_r  <= '0;
      minor_r  <= '0;
      step_r   <= '0;
      err_r    <= '0;
      xmaj_r   <= 1'b0;
      ydown_r  <= 1'b0;
      active_r <= 1'b0;
      cfrom_r  <= '0;
      neg_r    <= '0;
      divcnt_r <= '0;
      for (int c = 0; c < NUM_CHAN; c++) begin
        quo_r[c]  <= '0;
        rem_r[c]  <= '0;
        accq_r[c] <= '0;
        accr_r[c] <= '0;
      end
    end else if (cmd.load) begin
      cur_x_r  <= x0;
      cur_y_r  <= y0;
      major_r  <= ld_maj;
      minor_r  <= ld_min;
      step_r   <= '0;
      err_r    <= ld_err;
      xmaj_r   <= ld_xmaj;
      ydown_r  <= ld_ydown;
      active_r <= ld_maj != '0;
      cfrom_r  <= c0;
      neg_r    <= ld_neg;
      divcnt_r <= '0;
      for (int c = 0; c < NUM_CHAN; c++) begin
        quo_r[c]  <= ld_mag[c];
        rem_r[c]  <= '0;
        accq_r[c] <= '0;
        accr_r[c] <= '0;
      end
    end else if (cmd.div_step) begin
      // One quotient bit per channel per cycle.
      divcnt_r <= divcnt_r + DIV_CNT_W'(1);
      for (int c = 0; c < NUM_CHAN; c++) begin
        rem_r[c] <= tfit[c] ? COORD_W'(trial[c] - {1'b0, major_r}) : trial[c][COORD_W-1:0];
        quo_r[c] <= {quo_r[c][CHAN_W-2:0], tfit[c]};
      end
    end else if (cmd.step) begin
      err_r  <= st_err;
      step_r <= st_count;
      if (move_x) begin
        cur_x_r <= cur_x_r + COORD_W'(1);
      end
      if (move_y) begin
        cur_y_r <= ydown_r ? (cur_y_r - COORD_W'(1)) : (cur_y_r + COORD_W'(1));
      end
      if (st_count == major_r) begin
        active_r <= 1'b0;
      end
      // Color accumulators advance by quotient and remainder of |c1-c0|/n.
      for (int c = 0; c < NUM_CHAN; c++) begin
        accr_r[c] <= rwrap[c] ? COORD_W'(rsum[c] - {1'b0, major_r}) : rsum[c][COORD_W-1:0];
        accq_r[c] <= accq_r[c] + quo_r[c] + CHAN_W'(rwrap[c]);
      end
    end
  end

  // Result fields from the current state.
  logic [31:0] pix_index;
  always_comb begin
    pix_index = 32'(cur_x_r) + 32'(cur_y_r) * 32'(WIDTH);
    out_data  = {2'b00, chan_out[3], chan_out[2], chan_out[1], chan_out[0],
                 pix_index[ADDR_W-3:0], 2'b00, cur_y_r, cur_x_r};
    out_last  = step_r == major_r;
    status.line_active = active_r;
    status.div_last    = divcnt_r == {DIV_CNT_W{1'b1}};
  end

endmodule

`default_nettype wire

>>> hw/rtl/bresenham_line_color_raster.sv
// Top level of the midpoint line rasterizer with RGBA interpolation.
// Depends on blr_pkg, blr_ctrl and blr_datapath.
//
//   Channel  Direction  Payload
//   in_      slave      tdata: endpoints and colors; tuser: mode (load or step)
//   out_     master     tdata: pixel, address, color; tlast: final pixel of line
//
// A step is accepted and applied in ST_IDLE; ST_OUT then presents the pixel.
// A load runs the per-channel restoring divider in ST_DIV before ST_OUT.
// A step with no active line is absorbed and gives no pixel.
// Synchronous active-low reset clears all line state; no line is active after it.
// The result stays presented until out_tready; no input is taken meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module bresenham_line_color_raster #(
  parameter int WIDTH = 512
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  // x_start[8:0], y_start[17:9], x_end[26:18], y_end[35:27],
  // color_start[67:36], color_end[99:68], zero fill[103:100]
  input  wire [103:0] in_tdata,
  // mode[0]
  input  wire         in_tuser,
  output logic        out_tvalid,
  input  wire         out_tready,
  // pixel_x[8:0], pixel_y[17:9], byte_address[37:18], pixel_color[69:38],
  // zero fill[71:70]
  output logic [71:0] out_tdata,
  output logic        out_tlast
);
  import blr_pkg::*;

  cmd_t    cmd;
  status_t status;

  blr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_mode    (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  blr_datapath #(
    .WIDTH (WIDTH)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .status   (status),
    .in_data  (in_tdata),
    .out_data (out_tdata),
    .out_last (out_tlast)
  );

endmodule

`default_nettype wire

>>> hw/rtl/blr_checker.sv
// Port-level checks for the line rasterizer, bound to the top level.
// Depends on blr_pkg and bresenham_line_color_raster.
`timescale 1ns / 1ps
`default_nettype none

module blr_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_tvalid,
  input wire        in_tready,
  input wire [103:0] in_tdata,
  input wire        in_tuser,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [71:0] out_tdata,
  input wire        out_tlast
);
  import blr_pkg::*;

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // The block never takes input while a result waits.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input taken while a result is pending");

  // A load keeps the block busy with its division.
  a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == MODE_LOAD |=> !in_tready && !out_tvalid)
    else $error("load did not run the divider");

endmodule

bind bresenham_line_color_raster blr_checker u_blr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire
